@@ rtl/knn_pkg.sv @@
// ----------------------------------------------------------------------------
// knn_pkg
// Shared constants, item types and control structs for the k-nearest-neighbor
// search block.
// ----------------------------------------------------------------------------
package knn_pkg;

   localparam int K_MAX       = 32;
   localparam int COORD_BITS  = 16;
   localparam int INDEX_BITS  = 14;
   localparam int DIST_BITS   = 39;
   localparam int PROD_BITS   = 2 * COORD_BITS;
   localparam int COUNT_BITS  = 6;
   localparam int RANK_BITS   = 5;
   localparam int COUNT_RESET = 18;

   typedef struct packed {
      logic [COORD_BITS-1:0] query_coord;
      logic [COORD_BITS-1:0] cand_coord;
      logic [INDEX_BITS-1:0] cand_index;
      logic                  last_dim;
      logic                  last_cand;
   } req_type;

   typedef struct packed {
      logic [RANK_BITS-1:0]  rank;
      logic [INDEX_BITS-1:0] neighbor_index;
      logic                  found;
      logic                  last_result;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic square;
      logic accum;
      logic insert;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last_dim;
      logic last_cand;
      logic out_free;
      logic emit_done;
   } status_type;

endpackage

@@ rtl/knn_ctrl.sv @@
// ----------------------------------------------------------------------------
// knn_ctrl
// Sequencer: accept an item, square, accumulate, insert when the item closes
// a candidate, then drain the list on the final candidate.
// ----------------------------------------------------------------------------
module knn_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  knn_pkg::status_type status,
   output knn_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SQUARE = 5'b00010,
      ST_ACCUM  = 5'b00100,
      ST_INSERT = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            if (status.last_dim) state_in = ST_INSERT;
            else if (status.last_cand) state_in = ST_EMIT;
            else state_in = ST_IDLE;
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = status.last_cand ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
            if (status.out_free && status.emit_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/knn_datapath.sv @@
// ----------------------------------------------------------------------------
// knn_datapath
// Distance accumulator, sorted list of compare cells and result register.
// ----------------------------------------------------------------------------
module knn_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  knn_pkg::req_type                    req_data,
   input  logic                                csr_write,
   input  logic [knn_pkg::COUNT_BITS-1:0]      csr_data,
   input  knn_pkg::cmd_type                    cmd,
   output knn_pkg::status_type                 status,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output knn_pkg::rsp_type                    rsp_data
);

   localparam int KM = knn_pkg::K_MAX;
   localparam int CB = knn_pkg::COUNT_BITS;
   localparam int RB = knn_pkg::RANK_BITS;
   localparam int DB = knn_pkg::DIST_BITS;
   localparam int IB = knn_pkg::INDEX_BITS;
   localparam int PB = knn_pkg::PROD_BITS;

   knn_pkg::req_type           item_ff;
   logic [PB-1:0]              prod_ff;
   logic [DB-1:0]              accum_ff;
   logic [DB-1:0]              dist_ff;
   logic [CB-1:0]              fill_ff;
   logic [CB-1:0]              fill_in;
   logic [RB-1:0]              rank_ff;
   logic [CB-1:0]              count_ff;
   logic [DB-1:0]              dist_arr_ff [KM];
   logic [IB-1:0]              idx_arr_ff  [KM];
   logic                       rsp_valid_ff;
   knn_pkg::rsp_type           rsp_data_ff;

   logic [knn_pkg::COORD_BITS-1:0] diff;
   logic [DB:0]                sum;
   logic [DB-1:0]              sum_sat;
   logic [CB-1:0]              k_eff;
   logic [RB-1:0]              k_last;
   logic [CB-1:0]              fill_eff;
   logic [CB-1:0]              base;
   logic                       full;
   logic                       drop;
   logic [KM-1:0]              lt;
   logic [KM-1:0]              less;
   logic                       found;

   // effective k: zero acts as one, above the list size acts as the list size
   always_comb begin
      if (count_ff == '0) k_eff = CB'(1);
      else if (count_ff > CB'(KM)) k_eff = CB'(KM);
      else k_eff = count_ff;
   end
   assign k_last = RB'(k_eff - CB'(1));

   assign diff = (item_ff.query_coord >= item_ff.cand_coord) ?
                 (item_ff.query_coord - item_ff.cand_coord) :
                 (item_ff.cand_coord - item_ff.query_coord);

   assign sum     = {1'b0, accum_ff} + {{(DB+1-PB){1'b0}}, prod_ff};
   assign sum_sat = sum[DB] ? {DB{1'b1}} : sum[DB-1:0];

   assign fill_eff = (fill_ff > k_eff) ? k_eff : fill_ff;
   assign full     = (fill_eff == k_eff);
   assign base     = full ? (k_eff - CB'(1)) : fill_eff;

   always_comb begin
      for (int i = 0; i < KM; i++) begin
         lt[i]   = dist_ff < dist_arr_ff[i];
         less[i] = (CB'(i) < base) &&
                   ((dist_arr_ff[i] < dist_ff) ||
                    ((dist_arr_ff[i] == dist_ff) && (idx_arr_ff[i] < item_ff.cand_index)));
      end
   end

   assign drop = full && !lt[k_last];

   always_comb begin
      fill_in = fill_ff;
      if (cmd.insert) fill_in = drop ? fill_eff : base + CB'(1);
      else if (cmd.emit && status.emit_done) fill_in = '0;
   end

   assign found = ({1'b0, rank_ff} < fill_ff);

   assign status.last_dim  = item_ff.last_dim;
   assign status.last_cand = item_ff.last_cand;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.emit_done = (rank_ff == k_last);

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_data;
      if (cmd.square) prod_ff <= PB'(diff) * PB'(diff);
      if (cmd.accum) dist_ff <= sum_sat;
      if (cmd.insert && !drop) begin
         for (int i = 0; i < KM; i++) begin
            if (!less[i]) begin
               if (i == 0 || less[(i == 0) ? 0 : i-1]) begin
                  dist_arr_ff[i] <= dist_ff;
                  idx_arr_ff[i]  <= item_ff.cand_index;
               end else begin
                  dist_arr_ff[i] <= dist_arr_ff[(i == 0) ? 0 : i-1];
                  idx_arr_ff[i]  <= idx_arr_ff[(i == 0) ? 0 : i-1];
               end
            end
         end
      end else if (cmd.emit) begin
         // advance the list toward the head
         for (int i = 0; i < KM - 1; i++) begin
            dist_arr_ff[i] <= dist_arr_ff[i+1];
            idx_arr_ff[i]  <= idx_arr_ff[i+1];
         end
      end
      if (cmd.emit) begin
         rsp_data_ff.rank           <= rank_ff;
         rsp_data_ff.neighbor_index <= found ? idx_arr_ff[0] : '0;
         rsp_data_ff.found          <= found;
         rsp_data_ff.last_result    <= status.emit_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff     <= '0;
         fill_ff      <= '0;
         rank_ff      <= '0;
         count_ff     <= CB'(knn_pkg::COUNT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accum) begin
            accum_ff <= (item_ff.last_dim || item_ff.last_cand) ? '0 : sum_sat;
         end
         fill_ff <= fill_in;
         if (cmd.emit) rank_ff <= status.emit_done ? '0 : rank_ff + RB'(1);
         if (csr_write) count_ff <= csr_data;
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/knn_top_k_search.sv @@
// ----------------------------------------------------------------------------
// knn_top_k_search
// Brute-force k-nearest-neighbor search under squared Euclidean distance.
// ----------------------------------------------------------------------------
// Each item carries one coordinate of the query and of a candidate. An item
// is accepted, squared and accumulated, and when it closes a candidate its
// distance is then inserted into a sorted row of 32 compare cells in one
// step; the item sequencer sets these steps. The final candidate then drains
// k results, one a cycle while rsp_stall is low, before the next item is
// taken. The k register is written through csr_data.
module knn_top_k_search (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  knn_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output knn_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [knn_pkg::COUNT_BITS-1:0] csr_data
);

   knn_pkg::cmd_type    cmd;
   knn_pkg::status_type status;

   assign csr_ready = 1'b1;

   knn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   knn_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
